// ===== hdl/klt_pkg.sv =====
// keyed lock table package: table sizing, field widths, operation and status codes
// used by keyed_lock_table_core; depends on nothing else
package klt_pkg;

	// table sizing; ENTRIES must be a power of two so ring indexes wrap by truncation
	localparam int ENTRIES   = 16;
	localparam int SLOT_BITS = $clog2(ENTRIES);
	localparam int CNT_BITS  = SLOT_BITS + 1;
	localparam int KEY_BITS  = 64;
	localparam int REF_BITS  = 8;

	// fixed port widths
	localparam int KEY_IN_BITS = 64;
	localparam int MODE_BITS   = 2;
	localparam int STAT_BITS   = 3;
	localparam int HOLD_BITS   = 8;

	localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};
	localparam logic [CNT_BITS-1:0] FREE_ALL = CNT_BITS'(ENTRIES);

	// operation codes
	typedef enum logic [MODE_BITS-1:0] {
		MODE_LOCK    = 2'd0,
		MODE_TRYLOCK = 2'd1,
		MODE_UNLOCK  = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [STAT_BITS-1:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_BUSY      = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_FREED     = 3'd5,
		ST_HANDOFF   = 3'd6,
		ST_SATURATED = 3'd7
	} status_t;

	// entry update bundle from the decision logic to the table registers
	typedef struct packed {
		logic                 en;
		logic [SLOT_BITS-1:0] idx;
		logic                 valid;
		logic                 held;
		logic [REF_BITS-1:0]  refs;
		logic                 key_wr;
		logic                 pop;
		logic                 push;
	} upd_t;

endpackage

// ===== hdl/keyed_lock_table_core.sv =====
// keyed lock table core: key lookup, reference counting and free slot ring
// depends on klt_pkg
//
// usage:
// - input channel (in_valid, in_stall, mode, key) takes one request word: lock,
//   trylock or unlock of a key; the unused mode code is consumed without a result
// - output channel (out_valid, out_stall, status, slot, holders) returns one
//   result word per lock, trylock or unlock request, in request order
// - an accepted request word sits in the input register while the sixteen-way
//   key compare and entry update run, then lands in the result register
// - throughput: one request per cycle unless the receiver stalls a waiting
//   result; the table update for a request commits at the same edge that
//   loads its result, so the next request sees it at once
// - when the receiver stalls a waiting result, the input register holds its word
//   and in_stall rises until the result is taken; nothing is dropped
// - reset clears all entries, references and held flags, refills the free ring
//   with slots in order and empties both registers; no clearing pass is needed,
//   the block takes requests right after reset
module keyed_lock_table_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [klt_pkg::MODE_BITS-1:0]      mode,
	input  logic [klt_pkg::KEY_IN_BITS-1:0]    key,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [klt_pkg::STAT_BITS-1:0]      status,
	output logic [klt_pkg::SLOT_BITS-1:0]      slot,
	output logic [klt_pkg::HOLD_BITS-1:0]      holders
);

	// input register
	logic                                  valid_s1;
	klt_pkg::mode_t                        mode_s1;
	logic [klt_pkg::KEY_BITS-1:0]          key_s1;

	// result register
	logic                                  out_valid_q;
	klt_pkg::status_t                      status_q;
	logic [klt_pkg::SLOT_BITS-1:0]         slot_q;
	logic [klt_pkg::HOLD_BITS-1:0]         holders_q;

	// table state
	logic [klt_pkg::ENTRIES-1:0]           valid_q;
	logic [klt_pkg::ENTRIES-1:0]           held_q;
	logic [klt_pkg::REF_BITS-1:0]          refs_q  [klt_pkg::ENTRIES];
	logic [klt_pkg::KEY_BITS-1:0]          key_q   [klt_pkg::ENTRIES];
	logic [klt_pkg::SLOT_BITS-1:0]         ring_q  [klt_pkg::ENTRIES];
	logic [klt_pkg::SLOT_BITS-1:0]         head_q;
	logic [klt_pkg::CNT_BITS-1:0]          count_q;

	// decision logic outputs
	logic                                  advance;
	logic                                  fire;
	logic [klt_pkg::ENTRIES-1:0]           match;
	logic                                  hit;
	logic [klt_pkg::SLOT_BITS-1:0]         hit_idx;
	logic [klt_pkg::REF_BITS-1:0]          hit_refs;
	logic                                  hit_held;
	logic [klt_pkg::SLOT_BITS-1:0]         alloc_idx;
	logic [klt_pkg::SLOT_BITS-1:0]         tail_idx;
	logic                                  res_valid;
	klt_pkg::status_t                      res_status;
	logic [klt_pkg::SLOT_BITS-1:0]         res_slot;
	logic [klt_pkg::REF_BITS-1:0]          res_refs;
	klt_pkg::upd_t                         upd;

	// handshake: result register frees up when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	// parallel key compare, lowest matching slot wins
	always_comb begin
		for (int i = 0; i < klt_pkg::ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_s1);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = klt_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = klt_pkg::SLOT_BITS'(i);
			end
		end
	end

	assign hit       = |match;
	assign hit_refs  = refs_q[hit_idx];
	assign hit_held  = held_q[hit_idx];
	assign alloc_idx = ring_q[head_q];
	assign tail_idx  = head_q + count_q[klt_pkg::SLOT_BITS-1:0];

	// per-request decision and entry update
	always_comb begin
		res_valid  = 1'b1;
		res_status = klt_pkg::ST_GRANTED;
		res_slot   = '0;
		res_refs   = '0;
		upd        = '0;
		upd.idx    = hit_idx;
		case (mode_s1)
			klt_pkg::MODE_UNLOCK: begin
				if (!hit) begin
					res_status = klt_pkg::ST_NOTFOUND;
				end else if (hit_refs > klt_pkg::REF_BITS'(1)) begin
					upd.en     = 1'b1;
					upd.valid  = 1'b1;
					upd.held   = 1'b1;
					upd.refs   = hit_refs - klt_pkg::REF_BITS'(1);
					res_status = klt_pkg::ST_HANDOFF;
					res_slot   = hit_idx;
					res_refs   = upd.refs;
				end else begin
					// last reference gone: slot returns to the free ring
					upd.en     = 1'b1;
					upd.push   = (count_q < klt_pkg::FREE_ALL);
					res_status = klt_pkg::ST_FREED;
					res_slot   = hit_idx;
				end
			end
			klt_pkg::MODE_LOCK, klt_pkg::MODE_TRYLOCK: begin
				if (!hit) begin
					if (count_q == '0) begin
						res_status = klt_pkg::ST_FULL;
					end else begin
						// new key takes the oldest free slot
						upd.en     = 1'b1;
						upd.idx    = alloc_idx;
						upd.valid  = 1'b1;
						upd.held   = 1'b1;
						upd.refs   = klt_pkg::REF_BITS'(1);
						upd.key_wr = 1'b1;
						upd.pop    = 1'b1;
						res_status = klt_pkg::ST_GRANTED;
						res_slot   = alloc_idx;
						res_refs   = upd.refs;
					end
				end else if (mode_s1 == klt_pkg::MODE_TRYLOCK && hit_held) begin
					res_status = klt_pkg::ST_BUSY;
					res_slot   = hit_idx;
					res_refs   = hit_refs;
				end else if (hit_refs == klt_pkg::REF_MAX) begin
					res_status = klt_pkg::ST_SATURATED;
					res_slot   = hit_idx;
					res_refs   = hit_refs;
				end else begin
					upd.en     = 1'b1;
					upd.valid  = 1'b1;
					upd.held   = 1'b1;
					upd.refs   = hit_refs + klt_pkg::REF_BITS'(1);
					res_status = hit_held ? klt_pkg::ST_QUEUED : klt_pkg::ST_GRANTED;
					res_slot   = hit_idx;
					res_refs   = upd.refs;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= klt_pkg::mode_t'(mode);
			key_s1  <= key[klt_pkg::KEY_BITS-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			status_q  <= res_status;
			slot_q    <= res_slot;
			holders_q <= klt_pkg::HOLD_BITS'(res_refs);
		end
	end

	// entry flags, counts and free ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			held_q  <= '0;
			head_q  <= '0;
			count_q <= klt_pkg::FREE_ALL;
			for (int i = 0; i < klt_pkg::ENTRIES; i++) begin
				refs_q[i] <= '0;
				ring_q[i] <= klt_pkg::SLOT_BITS'(i);
			end
		end else if (fire && upd.en) begin
			valid_q[upd.idx] <= upd.valid;
			held_q[upd.idx]  <= upd.held;
			refs_q[upd.idx]  <= upd.refs;
			if (upd.pop) begin
				head_q  <= head_q + klt_pkg::SLOT_BITS'(1);
				count_q <= count_q - klt_pkg::CNT_BITS'(1);
			end
			if (upd.push) begin
				ring_q[tail_idx] <= upd.idx;
				count_q          <= count_q + klt_pkg::CNT_BITS'(1);
			end
		end
	end

	// key store, no reset
	always_ff @(posedge clk) begin
		if (fire && upd.en && upd.key_wr) begin
			key_q[upd.idx] <= key_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign holders   = holders_q;

`ifndef SYNTH
	// free ring never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= klt_pkg::FREE_ALL)
		else $error("free count above table size");

	// every slot is either in use or on the free ring
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(klt_pkg::CNT_BITS'($countones(valid_q)) + count_q) == klt_pkg::FREE_ALL)
		else $error("used and free slots do not add up");

	// an entry in use is always held, a free entry never
	a_held_valid: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == valid_q)
		else $error("held flags disagree with entry valid bits");

	// keys stay unique among entries in use
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match))
		else $error("key found in more than one entry");

	// a saturated result reports the full count
	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == klt_pkg::ST_SATURATED)
			|-> holders_q == klt_pkg::HOLD_BITS'(klt_pkg::REF_MAX))
		else $error("saturated result without full count");
`endif

endmodule

// ===== test/keyed_lock_table_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for keyed_lock_table_core: a directed table, then random lock traffic
// checked word by word against a behavioral copy of the lock table
// depends on klt_pkg and keyed_lock_table_core
module keyed_lock_table_core_tb;

	localparam int DIR_ROWS       = 22;
	localparam int RANDOM_WORDS   = 1900;
	localparam int POOL_KEYS      = 24;
	localparam int WATCHDOG_LIMIT = 500;

	typedef struct packed {
		klt_pkg::status_t              status;
		logic [klt_pkg::SLOT_BITS-1:0] slot;
		logic [klt_pkg::HOLD_BITS-1:0] holders;
	} lock_reply_t;

	typedef struct packed {
		klt_pkg::mode_t                  m;
		logic [klt_pkg::KEY_IN_BITS-1:0] k;
		logic                            typed;
		lock_reply_t                     want;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [klt_pkg::MODE_BITS-1:0]   mode;
	logic [klt_pkg::KEY_IN_BITS-1:0] key;
	logic                            out_valid;
	logic                            out_stall;
	logic [klt_pkg::STAT_BITS-1:0]   status;
	logic [klt_pkg::SLOT_BITS-1:0]   slot;
	logic [klt_pkg::HOLD_BITS-1:0]   holders;

	// behavioral copy of the table
	bit                            tab_valid [klt_pkg::ENTRIES];
	logic [klt_pkg::KEY_BITS-1:0]  tab_key   [klt_pkg::ENTRIES];
	logic [klt_pkg::REF_BITS-1:0]  tab_refs  [klt_pkg::ENTRIES];
	bit                            tab_held  [klt_pkg::ENTRIES];
	logic [klt_pkg::SLOT_BITS-1:0] ring      [klt_pkg::ENTRIES];
	logic [klt_pkg::SLOT_BITS-1:0] ring_head;
	int                            ring_fill;

	lock_reply_t                     reply_q[$];
	lock_reply_t                     monitor_want;
	stim_row_t                       dir_rows [DIR_ROWS];
	logic [klt_pkg::KEY_IN_BITS-1:0] key_pool [POOL_KEYS];

	int errors;
	int words_sent;
	int words_checked;
	int status_tally [8];
	int idle_cycles;
	int send_left, recv_left;
	bit send_quiet, recv_quiet;

	keyed_lock_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.slot      (slot),
		.holders   (holders)
	);

	// clock and one reset at the start
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// wait draw per word, with quiet stretches of back-to-back traffic
	function automatic int draw_gap(inout int left, inout bit quiet);
		if (left == 0) begin
			left  = $urandom_range(16, 64);
			quiet = ($urandom_range(0, 3) == 0);
		end
		left--;
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic int key_slot(input logic [klt_pkg::KEY_IN_BITS-1:0] k);
		int i;
		for (i = 0; i < klt_pkg::ENTRIES; i++)
			if (tab_valid[i] && tab_key[i] == k[klt_pkg::KEY_BITS-1:0])
				return i;
		return -1;
	endfunction

	// next reply of the lock table for one request, updating the table copy
	function automatic lock_reply_t predict_reply(input klt_pkg::mode_t m,
			input logic [klt_pkg::KEY_IN_BITS-1:0] k);
		lock_reply_t                   r;
		int                            hit;
		logic [klt_pkg::SLOT_BITS-1:0] u;
		r   = '0;
		hit = key_slot(k);
		// unlock: hand off while references remain, else free the slot
		if (m == klt_pkg::MODE_UNLOCK) begin
			if (hit < 0) begin
				r.status = klt_pkg::ST_NOTFOUND;
				return r;
			end
			u      = klt_pkg::SLOT_BITS'(hit);
			r.slot = u;
			if (tab_refs[u] > 1) begin
				tab_refs[u]--;
				tab_held[u] = 1'b1;
				r.status    = klt_pkg::ST_HANDOFF;
				r.holders   = klt_pkg::HOLD_BITS'(tab_refs[u]);
			end else begin
				tab_refs[u]  = '0;
				tab_held[u]  = 1'b0;
				tab_valid[u] = 1'b0;
				if (ring_fill < klt_pkg::ENTRIES) begin
					ring[klt_pkg::SLOT_BITS'(ring_head + ring_fill)] = u;
					ring_fill++;
				end
				r.status = klt_pkg::ST_FREED;
			end
			return r;
		end
		// new key takes the oldest free slot
		if (hit < 0) begin
			if (ring_fill == 0) begin
				r.status = klt_pkg::ST_FULL;
				return r;
			end
			u = ring[ring_head];
			ring_head++;
			ring_fill--;
			tab_valid[u] = 1'b1;
			tab_key[u]   = k[klt_pkg::KEY_BITS-1:0];
			tab_refs[u]  = klt_pkg::REF_BITS'(1);
			tab_held[u]  = 1'b1;
			r.status     = klt_pkg::ST_GRANTED;
			r.slot       = u;
			r.holders    = klt_pkg::HOLD_BITS'(1);
			return r;
		end
		// known key
		u      = klt_pkg::SLOT_BITS'(hit);
		r.slot = u;
		if (m == klt_pkg::MODE_TRYLOCK && tab_held[u])
			r.status = klt_pkg::ST_BUSY;
		else if (tab_refs[u] == klt_pkg::REF_MAX)
			r.status = klt_pkg::ST_SATURATED;
		else begin
			tab_refs[u]++;
			r.status    = tab_held[u] ? klt_pkg::ST_QUEUED : klt_pkg::ST_GRANTED;
			tab_held[u] = 1'b1;
		end
		r.holders = klt_pkg::HOLD_BITS'(tab_refs[u]);
		return r;
	endfunction

	// drive one request word and log its expected reply once accepted
	task automatic send_word(input klt_pkg::mode_t m,
			input logic [klt_pkg::KEY_IN_BITS-1:0] k,
			input bit typed, input lock_reply_t want);
		lock_reply_t pred;
		int          gap;
		gap = draw_gap(send_left, send_quiet);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode     <= m;
		key      <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (m != klt_pkg::MODE_NONE) begin
			pred = predict_reply(m, k);
			reply_q.push_back(typed ? want : pred);
			words_sent++;
		end
	endtask

	// sender holds off until every reply is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [klt_pkg::KEY_IN_BITS-1:0] fresh_key();
		return {$urandom, $urandom};
	endfunction

	function automatic klt_pkg::mode_t draw_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return klt_pkg::MODE_LOCK;
		else if (r < 58)
			return klt_pkg::MODE_TRYLOCK;
		return klt_pkg::MODE_UNLOCK;
	endfunction

	// random traffic: single ops, lock/unlock sequences, table fills, one saturation burst
	task automatic run_random();
		logic [klt_pkg::KEY_IN_BITS-1:0] k;
		logic [klt_pkg::KEY_IN_BITS-1:0] fill_keys[$];
		int                              pick, n, guard, s, i;
		bit                              burst_done;
		burst_done = 1'b0;
		while (words_sent < DIR_ROWS + RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (!burst_done && words_sent > 900) begin
				// saturate one key's count, then release it all the way
				burst_done = 1'b1;
				wait_drained();
				while (ring_fill == 0) begin
					for (i = 0; i < klt_pkg::ENTRIES && key_slot(tab_key[i]) != i; i++) ;
					send_word(klt_pkg::MODE_UNLOCK, tab_key[i], 1'b0, '0);
				end
				k = fresh_key();
				send_word(klt_pkg::MODE_LOCK, k, 1'b0, '0);
				s = key_slot(k);
				while (tab_refs[s] != klt_pkg::REF_MAX)
					send_word(($urandom_range(0, 9) == 0) ? klt_pkg::MODE_TRYLOCK
						: klt_pkg::MODE_LOCK, k, 1'b0, '0);
				repeat (3) send_word(klt_pkg::MODE_LOCK, k, 1'b0, '0);
				send_word(klt_pkg::MODE_TRYLOCK, k, 1'b0, '0);
				while (key_slot(k) >= 0)
					send_word(klt_pkg::MODE_UNLOCK, k, 1'b0, '0);
			end else if (pick < 45) begin
				send_word(draw_mode(), key_pool[$urandom_range(0, POOL_KEYS - 1)], 1'b0, '0);
			end else if (pick < 70) begin
				// well-formed: a few locks then unlocks until the slot is freed
				k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
					: fresh_key();
				n = $urandom_range(1, 4);
				repeat (n)
					send_word(($urandom_range(0, 3) == 0) ? klt_pkg::MODE_TRYLOCK
						: klt_pkg::MODE_LOCK, k, 1'b0, '0);
				guard = 0;
				while (key_slot(k) >= 0 && guard < 300) begin
					send_word(klt_pkg::MODE_UNLOCK, k, 1'b0, '0);
					guard++;
				end
			end else if (pick < 80) begin
				send_word(draw_mode(), fresh_key(), 1'b0, '0);
			end else if (pick < 85) begin
				// unused mode, ignored by the block
				send_word(klt_pkg::MODE_NONE, fresh_key(), 1'b0, '0);
			end else begin
				// fill the table, overflow it, then release a random part of the new keys
				fill_keys.delete();
				while (ring_fill > 0) begin
					k = fresh_key();
					fill_keys.push_back(k);
					send_word(klt_pkg::MODE_LOCK, k, 1'b0, '0);
				end
				send_word(klt_pkg::MODE_LOCK, fresh_key(), 1'b0, '0);
				send_word(klt_pkg::MODE_TRYLOCK, fresh_key(), 1'b0, '0);
				send_word(klt_pkg::MODE_UNLOCK, fresh_key(), 1'b0, '0);
				foreach (fill_keys[j])
					if ($urandom_range(0, 3) != 0)
						send_word(klt_pkg::MODE_UNLOCK, fill_keys[j], 1'b0, '0);
			end
		end
	endtask

	// stimulus
	initial begin
		int i;
		in_valid = 1'b0;
		mode     = klt_pkg::MODE_LOCK;
		key      = '0;
		for (i = 0; i < klt_pkg::ENTRIES; i++) begin
			tab_valid[i] = 1'b0;
			tab_key[i]   = '0;
			tab_refs[i]  = '0;
			tab_held[i]  = 1'b0;
			ring[i]      = klt_pkg::SLOT_BITS'(i);
		end
		ring_head = '0;
		ring_fill = klt_pkg::ENTRIES;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = fresh_key();
		key_pool[3] = key_pool[2] ^ 64'h1;
		key_pool[4] = key_pool[2] ^ 64'h8000_0000_0000_0000;
		for (i = 5; i < POOL_KEYS; i++)
			key_pool[i] = fresh_key();

		dir_rows = '{
			'{klt_pkg::MODE_LOCK,    64'h0,                   1'b1,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd1}},
			'{klt_pkg::MODE_LOCK,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
				'{klt_pkg::ST_GRANTED,  4'd1, 8'd1}},
			'{klt_pkg::MODE_LOCK,    64'h0,                   1'b1,
				'{klt_pkg::ST_QUEUED,   4'd0, 8'd2}},
			'{klt_pkg::MODE_TRYLOCK, 64'h0,                   1'b1,
				'{klt_pkg::ST_BUSY,     4'd0, 8'd2}},
			'{klt_pkg::MODE_TRYLOCK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
				'{klt_pkg::ST_BUSY,     4'd1, 8'd1}},
			'{klt_pkg::MODE_UNLOCK,  64'h0,                   1'b1,
				'{klt_pkg::ST_HANDOFF,  4'd0, 8'd1}},
			'{klt_pkg::MODE_UNLOCK,  64'h0,                   1'b1,
				'{klt_pkg::ST_FREED,    4'd0, 8'd0}},
			'{klt_pkg::MODE_UNLOCK,  64'h0,                   1'b1,
				'{klt_pkg::ST_NOTFOUND, 4'd0, 8'd0}},
			'{klt_pkg::MODE_NONE,    64'h5,                   1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_TRYLOCK, 64'h5555_5555_5555_5555, 1'b1,
				'{klt_pkg::ST_GRANTED,  4'd2, 8'd1}},
			'{klt_pkg::MODE_LOCK,    64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
				'{klt_pkg::ST_GRANTED,  4'd3, 8'd1}},
			'{klt_pkg::MODE_LOCK,    64'h5555_5555_5555_5555, 1'b1,
				'{klt_pkg::ST_QUEUED,   4'd2, 8'd2}},
			'{klt_pkg::MODE_UNLOCK,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
				'{klt_pkg::ST_FREED,    4'd3, 8'd0}},
			'{klt_pkg::MODE_UNLOCK,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
				'{klt_pkg::ST_FREED,    4'd1, 8'd0}},
			'{klt_pkg::MODE_LOCK,    64'h8000_0000_0000_0000, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_LOCK,    64'h0000_0000_0000_0001, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_TRYLOCK, 64'h8000_0000_0000_0000, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_UNLOCK,  64'h5555_5555_5555_5555, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_UNLOCK,  64'h5555_5555_5555_5555, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_UNLOCK,  64'h0000_0000_0000_0001, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_UNLOCK,  64'h8000_0000_0000_0000, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}},
			'{klt_pkg::MODE_NONE,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
				'{klt_pkg::ST_GRANTED,  4'd0, 8'd0}}
		};

		@(posedge arst_n);
		for (i = 0; i < DIR_ROWS; i++)
			send_word(dir_rows[i].m, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();
		run_random();
		wait_drained();

		$display("%0d request words sent, %0d result words checked", words_sent, words_checked);
		$display("table full %0d, refs saturated %0d, busy %0d, handed off %0d, freed %0d",
			status_tally[klt_pkg::ST_FULL], status_tally[klt_pkg::ST_SATURATED],
			status_tally[klt_pkg::ST_BUSY], status_tally[klt_pkg::ST_HANDOFF],
			status_tally[klt_pkg::ST_FREED]);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result receiver stalls at random
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_gap(recv_left, recv_quiet);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// compare each result word with the oldest expected reply
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d slot %0d holders %0d",
					status, slot, holders));
			end else begin
				monitor_want = reply_q.pop_front();
				if (status !== monitor_want.status)
					report_mismatch($sformatf("status got %0d want %0d", status,
						monitor_want.status));
				if (slot !== monitor_want.slot)
					report_mismatch($sformatf("slot got %0d want %0d", slot, monitor_want.slot));
				if (holders !== monitor_want.holders)
					report_mismatch($sformatf("holders got %0d want %0d", holders,
						monitor_want.holders));
				status_tally[monitor_want.status]++;
				words_checked++;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
